### rtl/mfar_pkg.sv
// Shared constants and helpers for the magnetic field angular rate block.
`timescale 1ns / 1ps

package mfar_pkg;

    localparam int INTERVAL_BITS  = 20;
    localparam int RATE_BITS      = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MUL_W          = 32;
    localparam int AXIS_BITS      = 14;
    localparam int Q16_BITS       = 16;
    localparam int US_BITS        = 20;
    localparam int DIV_CNT_BITS   = 5;
    localparam int HIST_DEPTH     = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_INTERVAL     = 2'd1;

    localparam logic [INTERVAL_BITS-1:0] RESET_INITIAL_INTERVAL = 20'd20000;
    localparam logic [INTERVAL_BITS-1:0] RESET_MIN_INTERVAL     = 20'd1000;

    localparam logic [US_BITS-1:0] US_PER_SECOND = 20'd1000000;

    localparam logic [RATE_BITS-2:0] RATE_MAX = '1;

    // next component index in x -> y -> z -> x order
    function automatic logic [1:0] next3(input logic [1:0] i);
        logic [1:0] r;
        if (i == 2'd2)
        begin
            r = 2'd0;
        end
        else
        begin
            r = i + 2'd1;
        end
        return r;
    endfunction

endpackage

### rtl/magnetic_field_angular_rate.sv
// Magnetic field angular rate estimator: history, shared multiplier sequencer, divider.
// Sequence per accepted beat: a short interval goes straight to the result beat; a zero
// axis stops after the axis terms; a zero projection adds the one-bit-per-cycle axis
// scaling, the cross product and the projection terms; a recomputed rate runs the rest of the
// term sequence of the single 32x32 multiplier and the restoring divider per component (ending early if it saturates).
// Throughput: one beat at a time; in_stall stays high until the result beat is loaded.
// Reset: control, held rate and registers return to defaults at once; no clearing pass.
`timescale 1ns / 1ps

module magnetic_field_angular_rate #(
    parameter int FIELD_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [FIELD_BITS-1:0]            field_x,
    input  logic signed [FIELD_BITS-1:0]            field_y,
    input  logic signed [FIELD_BITS-1:0]            field_z,
    input  logic [mfar_pkg::INTERVAL_BITS-1:0]      interval_us,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [mfar_pkg::RATE_BITS-1:0]   rate_x,
    output logic signed [mfar_pkg::RATE_BITS-1:0]   rate_y,
    output logic signed [mfar_pkg::RATE_BITS-1:0]   rate_z,
    output logic                                    rate_updated,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mfar_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mfar_pkg::INTERVAL_BITS-1:0]      cfg_data
);

    // Widths of every intermediate, all exact for the worst-case field values.
    localparam int F      = FIELD_BITS;
    localparam int WD     = F + 1;                          // sample difference
    localparam int WAX    = 2 * F + 3;                      // raw axis
    localparam int WAP    = mfar_pkg::AXIS_BITS + 1;        // scaled axis
    localparam int WC     = 2 * F + 1;                      // H2 x H1
    localparam int WE     = WAP + F + 1;                    // a' x H2
    localparam int WDOT   = WAP + WC + 2;                   // a' . (H2 x H1)
    localparam int WESQ   = 2 * WE;                         // |a' x H2|^2
    localparam int WDEN   = WESQ + mfar_pkg::INTERVAL_BITS; // times dt
    localparam int WDD    = WDOT + mfar_pkg::US_BITS - 1;   // |dot| * 1e6
    localparam int WNUM0  = WDD + mfar_pkg::AXIS_BITS;      // times |a'_i|
    localparam int WNUM   = WNUM0 + mfar_pkg::Q16_BITS;
    localparam int WDSH   = WDEN + mfar_pkg::RATE_BITS - 1;
    localparam int WCMP   = (WNUM > WDSH) ? WNUM : WDSH;
    localparam int WOP    = (WESQ > WDD) ? WESQ : WDD;
    localparam int WACC   = ((WNUM0 > WDEN) ? WNUM0 : WDEN) + 1;
    localparam int MW     = mfar_pkg::MUL_W;
    localparam int NCH    = (WOP + MW - 1) / MW;
    localparam int NPW    = NCH * MW;
    localparam int CB     = $clog2(NCH);

    localparam logic [CB:0] NC_D   = (CB+1)'((WD + MW - 1) / MW);
    localparam logic [CB:0] NC_H   = (CB+1)'((F + MW - 1) / MW);
    localparam logic [CB:0] NC_AP  = (CB+1)'((WAP + MW - 1) / MW);
    localparam logic [CB:0] NC_C   = (CB+1)'((WC + MW - 1) / MW);
    localparam logic [CB:0] NC_E   = (CB+1)'((WE + MW - 1) / MW);
    localparam logic [CB:0] NC_ESQ = (CB+1)'((WESQ + MW - 1) / MW);
    localparam logic [CB:0] NC_IV  = (CB+1)'((mfar_pkg::INTERVAL_BITS + MW - 1) / MW);
    localparam logic [CB:0] NC_DOT = (CB+1)'((WDOT + MW - 1) / MW);
    localparam logic [CB:0] NC_US  = (CB+1)'((mfar_pkg::US_BITS + MW - 1) / MW);
    localparam logic [CB:0] NC_DD  = (CB+1)'((WDD + MW - 1) / MW);

    localparam logic [mfar_pkg::DIV_CNT_BITS-1:0] DIV_TOP =
        mfar_pkg::DIV_CNT_BITS'(mfar_pkg::RATE_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_CHKAX, S_SCALE, S_CHKE, S_DIV, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_AX, PH_C, PH_E, PH_DOT, PH_E2, PH_DEN, PH_DD, PH_NUM
    } phase_t;

    // Control state
    state_t                               state_reg;
    phase_t                               phase_reg;
    logic [2:0]                           idx_reg;
    logic [CB-1:0]                        cx_reg;
    logic [CB-1:0]                        cy_reg;
    logic                                 upd_reg;
    logic                                 first_reg;
    logic [mfar_pkg::INTERVAL_BITS-1:0]   held_iv_reg;
    logic [mfar_pkg::INTERVAL_BITS-1:0]   min_iv_reg;
    logic signed [mfar_pkg::RATE_BITS-1:0] held_rate_reg [3];
    logic signed [mfar_pkg::RATE_BITS-1:0] rate_reg [3];
    logic                                 out_valid_reg;
    logic                                 rate_upd_reg;

    // Datapath
    logic signed [F-1:0]                  hist_reg [mfar_pkg::HIST_DEPTH][3];
    logic signed [WACC-1:0]               acc_reg;
    logic signed [WAX-1:0]                ax_reg [3];
    logic [WAX-1:0]                       axm_reg [3];
    logic [2:0]                           axs_reg;
    logic [WAX-1:0]                       mx_reg;
    logic signed [WC-1:0]                 c_reg [3];
    logic signed [WE-1:0]                 e_reg [3];
    logic signed [WDOT-1:0]               dot_reg;
    logic [WESQ-1:0]                      esq_reg;
    logic [WDEN-1:0]                      den_reg;
    logic [WDD-1:0]                       dd_reg;
    logic [WNUM-1:0]                      rem_reg;
    logic [WDSH-1:0]                      dsh_reg;
    logic [mfar_pkg::RATE_BITS-2:0]       q_reg;
    logic [mfar_pkg::DIV_CNT_BITS-1:0]    div_cnt_reg;
    logic signed [mfar_pkg::RATE_BITS-1:0] rate_work_reg [3];

    // Combinational
    logic signed [F-1:0]                  f_w [3];
    logic signed [WD-1:0]                 d1_w [3];
    logic signed [WD-1:0]                 d2_w [3];
    logic signed [WAP-1:0]                ap_w [3];
    logic [WAX-1:0]                       axabs_w [3];
    logic [WAX-1:0]                       mx_w;
    logic [mfar_pkg::INTERVAL_BITS-1:0]   iv_eff;
    logic [1:0]                           ci;
    logic [1:0]                           n1;
    logic [1:0]                           n2;
    logic [1:0]                           comp;
    logic signed [WOP:0]                  x_val;
    logic signed [WOP:0]                  y_val;
    logic [WOP:0]                         x_abs;
    logic [WOP:0]                         y_abs;
    logic [NPW-1:0]                       x_pad;
    logic [NPW-1:0]                       y_pad;
    logic [MW-1:0]                        x_chunk;
    logic [MW-1:0]                        y_chunk;
    logic [2*MW-1:0]                      prod;
    logic signed [WACC-1:0]               term;
    logic signed [WACC-1:0]               acc_next;
    logic                                 sub_t;
    logic                                 mag_only;
    logic                                 term_neg;
    logic [CB:0]                          nx;
    logic [CB:0]                          ny;
    logic                                 grp_end;
    logic                                 cx_last;
    logic                                 cy_last;
    logic                                 term_done;
    logic                                 e_zero;
    logic                                 div_ge;
    logic                                 div_done;
    logic                                 div_neg;
    logic [mfar_pkg::RATE_BITS-2:0]       q_fin;
    logic                                 out_free;

    assign in_stall     = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign rate_x       = rate_reg[0];
    assign rate_y       = rate_reg[1];
    assign rate_z       = rate_reg[2];
    assign rate_updated = rate_upd_reg;
    assign out_free     = !out_valid_reg || !out_stall;

    assign f_w[0] = field_x;
    assign f_w[1] = field_y;
    assign f_w[2] = field_z;

    // A zero interval keeps the held one
    assign iv_eff = (interval_us != '0) ? interval_us : held_iv_reg;

    // Successive differences, the scaled axis and the raw axis magnitudes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_w[i] = WD'(hist_reg[1][i]) - WD'(hist_reg[0][i]);
            d2_w[i] = WD'(hist_reg[2][i]) - WD'(hist_reg[1][i]);
            if (axs_reg[i])
            begin
                ap_w[i] = -$signed({1'b0, axm_reg[i][mfar_pkg::AXIS_BITS-1:0]});
            end
            else
            begin
                ap_w[i] = $signed({1'b0, axm_reg[i][mfar_pkg::AXIS_BITS-1:0]});
            end
            axabs_w[i] = ax_reg[i][WAX-1] ? WAX'(-ax_reg[i]) : WAX'(ax_reg[i]);
        end
        mx_w = axabs_w[0];
        if (axabs_w[1] > mx_w)
        begin
            mx_w = axabs_w[1];
        end
        if (axabs_w[2] > mx_w)
        begin
            mx_w = axabs_w[2];
        end
    end

    assign e_zero = (e_reg[0] == '0) && (e_reg[1] == '0) && (e_reg[2] == '0);

    // Term decode: which operands feed the multiplier for this phase and index.
    // Cross products take two terms per component, the second one subtracted.
    assign ci   = idx_reg[2:1];
    assign n1   = mfar_pkg::next3(ci);
    assign n2   = mfar_pkg::next3(n1);
    assign comp = idx_reg[1:0];

    always_comb
    begin
        x_val    = '0;
        y_val    = '0;
        sub_t    = idx_reg[0];
        mag_only = 1'b0;
        nx       = NC_D;
        ny       = NC_D;
        grp_end  = idx_reg[0];
        case (phase_reg)
            PH_AX:
            begin
                x_val = (WOP+1)'(idx_reg[0] ? d1_w[n2] : d1_w[n1]);
                y_val = (WOP+1)'(idx_reg[0] ? d2_w[n1] : d2_w[n2]);
            end
            PH_C:
            begin
                x_val = (WOP+1)'(idx_reg[0] ? hist_reg[2][n2] : hist_reg[2][n1]);
                y_val = (WOP+1)'(idx_reg[0] ? hist_reg[1][n1] : hist_reg[1][n2]);
                nx    = NC_H;
                ny    = NC_H;
            end
            PH_E:
            begin
                x_val = (WOP+1)'(idx_reg[0] ? ap_w[n2] : ap_w[n1]);
                y_val = (WOP+1)'(idx_reg[0] ? hist_reg[2][n1] : hist_reg[2][n2]);
                nx    = NC_AP;
                ny    = NC_H;
            end
            PH_DOT:
            begin
                x_val   = (WOP+1)'(ap_w[comp]);
                y_val   = (WOP+1)'(c_reg[comp]);
                sub_t   = 1'b0;
                nx      = NC_AP;
                ny      = NC_C;
                grp_end = (comp == 2'd2);
            end
            PH_E2:
            begin
                x_val   = (WOP+1)'(e_reg[comp]);
                y_val   = (WOP+1)'(e_reg[comp]);
                sub_t   = 1'b0;
                nx      = NC_E;
                ny      = NC_E;
                grp_end = (comp == 2'd2);
            end
            PH_DEN:
            begin
                x_val   = (WOP+1)'(esq_reg);
                y_val   = (WOP+1)'(held_iv_reg);
                sub_t   = 1'b0;
                nx      = NC_ESQ;
                ny      = NC_IV;
                grp_end = 1'b1;
            end
            PH_DD:
            begin
                x_val    = (WOP+1)'(dot_reg);
                y_val    = (WOP+1)'(mfar_pkg::US_PER_SECOND);
                sub_t    = 1'b0;
                mag_only = 1'b1;
                nx       = NC_DOT;
                ny       = NC_US;
                grp_end  = 1'b1;
            end
            PH_NUM:
            begin
                x_val    = (WOP+1)'(dd_reg);
                y_val    = (WOP+1)'(axm_reg[comp][mfar_pkg::AXIS_BITS-1:0]);
                sub_t    = 1'b0;
                mag_only = 1'b1;
                nx       = NC_DD;
                ny       = NC_AP;
                grp_end  = 1'b1;
            end
            default:
            begin
                sub_t = 1'b0;
            end
        endcase
    end

    // Shared multiplier: one 32x32 chunk product per cycle, shifted into the accumulator
    always_comb
    begin
        x_abs    = x_val[WOP] ? (WOP+1)'(-x_val) : (WOP+1)'(x_val);
        y_abs    = y_val[WOP] ? (WOP+1)'(-y_val) : (WOP+1)'(y_val);
        x_pad    = NPW'(x_abs[WOP-1:0]);
        y_pad    = NPW'(y_abs[WOP-1:0]);
        x_chunk  = x_pad[cx_reg*MW +: MW];
        y_chunk  = y_pad[cy_reg*MW +: MW];
        prod     = x_chunk * y_chunk;
        term     = $signed(WACC'(prod) << (MW * (int'(cx_reg) + int'(cy_reg))));
        term_neg = (x_val[WOP] ^ y_val[WOP] ^ sub_t) & ~mag_only;
        acc_next = term_neg ? (acc_reg - term) : (acc_reg + term);
    end

    assign cx_last   = ((CB+1)'(cx_reg) + (CB+1)'(1)) == nx;
    assign cy_last   = ((CB+1)'(cy_reg) + (CB+1)'(1)) == ny;
    assign term_done = cx_last && cy_last;

    // Restoring divider, one quotient bit per cycle; the top step only tests saturation
    assign div_ge   = WCMP'(rem_reg) >= WCMP'(dsh_reg);
    assign div_done = ((div_cnt_reg == DIV_TOP) && div_ge) || (div_cnt_reg == '0);
    assign div_neg  = dot_reg[WDOT-1] ^ axs_reg[comp];

    always_comb
    begin
        q_fin = q_reg;
        if (div_cnt_reg == DIV_TOP)
        begin
            q_fin = mfar_pkg::RATE_MAX;
        end
        else if (div_ge)
        begin
            q_fin[div_cnt_reg] = 1'b1;
        end
    end

    // Sequencer, configuration, held state and the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_AX;
            idx_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            upd_reg       <= 1'b0;
            first_reg     <= 1'b1;
            held_iv_reg   <= mfar_pkg::RESET_INITIAL_INTERVAL;
            min_iv_reg    <= mfar_pkg::RESET_MIN_INTERVAL;
            out_valid_reg <= 1'b0;
            rate_upd_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                held_rate_reg[i] <= '0;
                rate_reg[i]      <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    mfar_pkg::CFG_INITIAL_INTERVAL: held_iv_reg <= cfg_data;
                    mfar_pkg::CFG_MIN_INTERVAL:     min_iv_reg  <= cfg_data;
                    default:                        ;
                endcase
            end
            // drop the beat once taken, unless the next one loads now
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        first_reg   <= 1'b0;
                        held_iv_reg <= iv_eff;
                        upd_reg     <= 1'b0;
                        phase_reg   <= PH_AX;
                        idx_reg     <= '0;
                        cx_reg      <= '0;
                        cy_reg      <= '0;
                        // short interval: hold the rate
                        state_reg   <= (iv_eff > min_iv_reg) ? S_MUL : S_DONE;
                    end
                end
                S_MUL:
                begin
                    // advance the chunk counters, then the term
                    if (cy_last)
                    begin
                        cy_reg <= '0;
                        if (cx_last)
                        begin
                            cx_reg <= '0;
                        end
                        else
                        begin
                            cx_reg <= cx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cy_reg <= cy_reg + 1'b1;
                    end
                    if (term_done)
                    begin
                        case (phase_reg)
                            PH_AX:
                            begin
                                if (idx_reg == 3'd5)
                                begin
                                    state_reg <= S_CHKAX;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 3'd1;
                                end
                            end
                            PH_C:
                            begin
                                if (idx_reg == 3'd5)
                                begin
                                    phase_reg <= PH_E;
                                    idx_reg   <= '0;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 3'd1;
                                end
                            end
                            PH_E:
                            begin
                                if (idx_reg == 3'd5)
                                begin
                                    state_reg <= S_CHKE;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 3'd1;
                                end
                            end
                            PH_DOT:
                            begin
                                if (idx_reg == 3'd2)
                                begin
                                    phase_reg <= PH_E2;
                                    idx_reg   <= '0;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 3'd1;
                                end
                            end
                            PH_E2:
                            begin
                                if (idx_reg == 3'd2)
                                begin
                                    phase_reg <= PH_DEN;
                                    idx_reg   <= '0;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg + 3'd1;
                                end
                            end
                            PH_DEN:
                            begin
                                phase_reg <= PH_DD;
                                idx_reg   <= '0;
                            end
                            PH_DD:
                            begin
                                phase_reg <= PH_NUM;
                                idx_reg   <= '0;
                            end
                            PH_NUM:
                            begin
                                // keep the component index for the divider
                                state_reg <= S_DIV;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CHKAX:
                begin
                    // zero axis (first or repeated samples): hold the rate
                    state_reg <= (mx_w == '0) ? S_DONE : S_SCALE;
                end
                S_SCALE:
                begin
                    if ((mx_reg >> mfar_pkg::AXIS_BITS) == '0)
                    begin
                        state_reg <= S_MUL;
                        phase_reg <= PH_C;
                        idx_reg   <= '0;
                    end
                end
                S_CHKE:
                begin
                    // no projection left: hold the rate
                    if (e_zero)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                        phase_reg <= PH_DOT;
                        idx_reg   <= '0;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (comp == 2'd2)
                        begin
                            upd_reg   <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 3'd1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        rate_upd_reg  <= upd_reg;
                        for (int i = 0; i < 3; i++)
                        begin
                            rate_reg[i] <= upd_reg ? rate_work_reg[i] : held_rate_reg[i];
                            if (upd_reg)
                            begin
                                held_rate_reg[i] <= rate_work_reg[i];
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // shift the history; the first sample fills every slot
                    for (int i = 0; i < 3; i++)
                    begin
                        hist_reg[0][i] <= first_reg ? f_w[i] : hist_reg[1][i];
                        hist_reg[1][i] <= first_reg ? f_w[i] : hist_reg[2][i];
                        hist_reg[2][i] <= f_w[i];
                    end
                    acc_reg <= '0;
                end
            end
            S_MUL:
            begin
                acc_reg <= (term_done && grp_end) ? '0 : acc_next;
                if (term_done && grp_end)
                begin
                    case (phase_reg)
                        PH_AX:  ax_reg[ci] <= acc_next[WAX-1:0];
                        PH_C:   c_reg[ci]  <= acc_next[WC-1:0];
                        PH_E:   e_reg[ci]  <= acc_next[WE-1:0];
                        PH_DOT: dot_reg    <= acc_next[WDOT-1:0];
                        PH_E2:  esq_reg    <= acc_next[WESQ-1:0];
                        PH_DEN: den_reg    <= acc_next[WDEN-1:0];
                        PH_DD:  dd_reg     <= acc_next[WDD-1:0];
                        PH_NUM:
                        begin
                            rem_reg     <= WNUM'(acc_next[WNUM0-1:0]) << mfar_pkg::Q16_BITS;
                            dsh_reg     <= WDSH'(den_reg) << (mfar_pkg::RATE_BITS - 1);
                            div_cnt_reg <= DIV_TOP;
                            q_reg       <= '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHKAX:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    axm_reg[i] <= axabs_w[i];
                    axs_reg[i] <= ax_reg[i][WAX-1];
                end
                mx_reg <= mx_w;
            end
            S_SCALE:
            begin
                // drop one bit from every component until the largest fits
                if ((mx_reg >> mfar_pkg::AXIS_BITS) != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        axm_reg[i] <= axm_reg[i] >> 1;
                    end
                    mx_reg <= mx_reg >> 1;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg != DIV_TOP && div_ge)
                begin
                    rem_reg            <= rem_reg - WNUM'(dsh_reg);
                    q_reg[div_cnt_reg] <= 1'b1;
                end
                dsh_reg     <= dsh_reg >> 1;
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_done)
                begin
                    if (div_neg)
                    begin
                        rate_work_reg[comp] <= -$signed({1'b0, q_fin});
                    end
                    else
                    begin
                        rate_work_reg[comp] <= $signed({1'b0, q_fin});
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    // an accepted beat makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block took a beat without going busy");

    // chunk counters stay inside the current term
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (((CB+1)'(cx_reg) < nx) && ((CB+1)'(cy_reg) < ny)))
        else $error("multiplier chunk counter out of range");

    // restoring divider keeps the remainder below twice the shifted divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_cnt_reg != DIV_TOP)
            |-> ((WCMP+1)'(rem_reg) < {WCMP'(dsh_reg), 1'b0}))
        else $error("divider remainder out of range");

    // a result beat appears only from the completion state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside completion");
`endif

endmodule

### verif/mfar_checker.sv
// Checker for the angular rate block: predicts each result beat and compares it.
`timescale 1ns / 1ps

module mfar_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic signed [15:0]                    field_x,
    input  logic signed [15:0]                    field_y,
    input  logic signed [15:0]                    field_z,
    input  logic [mfar_pkg::INTERVAL_BITS-1:0]    interval_us,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [mfar_pkg::RATE_BITS-1:0] rate_x,
    input  logic signed [mfar_pkg::RATE_BITS-1:0] rate_y,
    input  logic signed [mfar_pkg::RATE_BITS-1:0] rate_z,
    input  logic                                  rate_updated,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [mfar_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mfar_pkg::INTERVAL_BITS-1:0]    cfg_data,
    output int                                    fail_count,
    output int                                    rates_pending,
    output int                                    recomputed_count
);

    typedef struct packed {
        logic signed [mfar_pkg::RATE_BITS-1:0] rx;
        logic signed [mfar_pkg::RATE_BITS-1:0] ry;
        logic signed [mfar_pkg::RATE_BITS-1:0] rz;
        logic                                  upd;
    } rate_beat_t;

    rate_beat_t rate_queue[$];

    logic [mfar_pkg::INTERVAL_BITS-1:0] min_iv;
    logic [mfar_pkg::INTERVAL_BITS-1:0] held_iv;
    longint                             hist[3][3];
    logic                               first_pending;
    longint                             held_rate[3];

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Recompute the rate from the current history; return 0 when the rate is held.
    function automatic bit recompute();
        longint d1[3], d2[3], ax[3], ap[3], c[3], e[3], h0[3], h1[3], h2[3];
        longint dot, mx, me;
        int s;
        logic [127:0] den, num, q;
        mx = 0;
        s = 0;
        den = '0;
        for (int i = 0; i < 3; i++)
        begin
            h0[i] = hist[0][i];
            h1[i] = hist[1][i];
            h2[i] = hist[2][i];
            d1[i] = h1[i] - h0[i];
            d2[i] = h2[i] - h1[i];
        end
        ax[0] = d1[1] * d2[2] - d1[2] * d2[1];
        ax[1] = d1[2] * d2[0] - d1[0] * d2[2];
        ax[2] = d1[0] * d2[1] - d1[1] * d2[0];
        for (int i = 0; i < 3; i++)
            if (mag(ax[i]) > mx)
                mx = mag(ax[i]);
        if (mx == 0)
            return 0;
        while ((mx >> s) >= 16384)
            s++;
        for (int i = 0; i < 3; i++)
            ap[i] = (ax[i] < 0) ? -(mag(ax[i]) >> s) : (mag(ax[i]) >> s);
        c[0] = h2[1] * h1[2] - h2[2] * h1[1];
        c[1] = h2[2] * h1[0] - h2[0] * h1[2];
        c[2] = h2[0] * h1[1] - h2[1] * h1[0];
        dot = ap[0] * c[0] + ap[1] * c[1] + ap[2] * c[2];
        e[0] = ap[1] * h2[2] - ap[2] * h2[1];
        e[1] = ap[2] * h2[0] - ap[0] * h2[2];
        e[2] = ap[0] * h2[1] - ap[1] * h2[0];
        if (e[0] == 0 && e[1] == 0 && e[2] == 0)
            return 0;
        for (int i = 0; i < 3; i++)
        begin
            me = mag(e[i]);
            den = den + 128'(me * me) * 128'(held_iv);
        end
        for (int i = 0; i < 3; i++)
        begin
            num = 128'(mag(dot)) * 128'(mag(ap[i])) * 128'(65536) * 128'(1000000);
            if ((num >> 31) >= den)
                q = 128'(32'h7FFF_FFFF);
            else
                q = num / den;
            held_rate[i] = ((dot < 0) != (ap[i] < 0)) ? -longint'(q[31:0]) : longint'(q[31:0]);
        end
        return 1;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rate_beat_t want;
        longint f[3];
        bit upd;
        if (!rst_n)
        begin
            min_iv        <= mfar_pkg::RESET_MIN_INTERVAL;
            held_iv       = mfar_pkg::RESET_INITIAL_INTERVAL;
            first_pending = 1'b1;
            for (int j = 0; j < 3; j++)
            begin
                held_rate[j] = 0;
                for (int i = 0; i < 3; i++)
                    hist[j][i] = 0;
            end
            rate_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mfar_pkg::CFG_INITIAL_INTERVAL)
                begin
                    held_iv = cfg_data;
                end
                else if (cfg_index == mfar_pkg::CFG_MIN_INTERVAL)
                begin
                    min_iv <= cfg_data;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (rate_queue.size() == 0)
                begin
                    report("unexpected beat", 0, 0);
                end
                else
                begin
                    want = rate_queue.pop_front();
                    if (rate_x !== want.rx) report("rate_x", rate_x, want.rx);
                    if (rate_y !== want.ry) report("rate_y", rate_y, want.ry);
                    if (rate_z !== want.rz) report("rate_z", rate_z, want.rz);
                    if (rate_updated !== want.upd)
                        report("rate_updated", rate_updated, want.upd);
                end
            end
            if (in_valid && !in_stall)
            begin
                f[0] = field_x;
                f[1] = field_y;
                f[2] = field_z;
                if (interval_us != 0)
                    held_iv = interval_us;
                for (int j = 0; j < 3; j++)
                    for (int i = 0; i < 3; i++)
                        hist[j][i] = (first_pending || j == 2) ? f[i] : hist[j + 1][i];
                first_pending = 1'b0;
                upd = (held_iv > min_iv) ? recompute() : 1'b0;
                if (upd)
                    recomputed_count++;
                want.rx = held_rate[0][31:0];
                want.ry = held_rate[1][31:0];
                want.rz = held_rate[2][31:0];
                want.upd = upd;
                rate_queue.push_back(want);
            end
        end
        rates_pending = rate_queue.size();
    end

    initial
    begin
        fail_count = 0;
        rates_pending = 0;
        recomputed_count = 0;
    end

endmodule

### verif/tb.sv
// Top of the angular rate testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    // Register indexes the block does not decode; writes to them must be ignored.
    localparam logic [mfar_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [mfar_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_stall;
    logic signed [15:0]                    field_x;
    logic signed [15:0]                    field_y;
    logic signed [15:0]                    field_z;
    logic [mfar_pkg::INTERVAL_BITS-1:0]    interval_us;
    logic                                  out_valid;
    logic                                  out_stall;
    logic signed [mfar_pkg::RATE_BITS-1:0] rate_x;
    logic signed [mfar_pkg::RATE_BITS-1:0] rate_y;
    logic signed [mfar_pkg::RATE_BITS-1:0] rate_z;
    logic                                  rate_updated;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [mfar_pkg::CFG_INDEX_BITS-1:0]   cfg_index;
    logic [mfar_pkg::INTERVAL_BITS-1:0]    cfg_data;

    int     fail_count;
    int     rates_pending;
    int     recomputed_count;
    int     samples_sent;
    int     settings_used;
    bit     quiet;          // no idling on either side while set
    longint cycle_count = 0;
    logic signed [15:0] walk[3];

    magnetic_field_angular_rate uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .field_x      (field_x),
        .field_y      (field_y),
        .field_z      (field_z),
        .interval_us  (interval_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rate_x       (rate_x),
        .rate_y       (rate_y),
        .rate_z       (rate_z),
        .rate_updated (rate_updated),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    mfar_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .field_x          (field_x),
        .field_y          (field_y),
        .field_z          (field_z),
        .interval_us      (interval_us),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .rate_x           (rate_x),
        .rate_y           (rate_y),
        .rate_z           (rate_z),
        .rate_updated     (rate_updated),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .rates_pending    (rates_pending),
        .recomputed_count (recomputed_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog: abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side backpressure: stall about a quarter of the cycles unless quiet.
    always @(posedge clk)
    begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 26);
    end

    // Present one sample beat and hold it until accepted, then maybe idle.
    // Called at a rising edge; returns at the edge where the next beat may start.
    task automatic send_sample(input logic signed [15:0] fx, input logic signed [15:0] fy,
                               input logic signed [15:0] fz,
                               input logic [mfar_pkg::INTERVAL_BITS-1:0] iv);
        in_valid    <= 1'b1;
        field_x     <= fx;
        field_y     <= fy;
        field_z     <= fz;
        interval_us <= iv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        samples_sent++;
        if (!quiet && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 26);
        end
    endtask

    // Drop valid, then hold until every predicted beat has drained.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (rates_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mfar_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [mfar_pkg::INTERVAL_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [mfar_pkg::INTERVAL_BITS-1:0] pick_interval();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return mfar_pkg::INTERVAL_BITS'($urandom_range(1500));
        else if (r < 25)
            return mfar_pkg::INTERVAL_BITS'($urandom());
        else
            return mfar_pkg::INTERVAL_BITS'($urandom_range(50000, 1000));
    endfunction

    // Mostly a slowly turning field so that the history forms a real rotation; some noise.
    task automatic random_samples(input int count);
        int step;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 15)
            begin
                for (int i = 0; i < 3; i++)
                    walk[i] = 16'($urandom());
            end
            else
            begin
                step = ($urandom_range(99) < 50) ? 64 : 4000;
                for (int i = 0; i < 3; i++)
                    walk[i] = walk[i] + 16'($urandom_range(2 * step) - step);
            end
            send_sample(walk[0], walk[1], walk[2], pick_interval());
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        field_x     = '0;
        field_y     = '0;
        field_z     = '0;
        interval_us = '0;
        cfg_valid   = 1'b0;
        cfg_index   = mfar_pkg::CFG_INITIAL_INTERVAL;
        cfg_data    = '0;
        samples_sent = 0;
        settings_used = 1;
        quiet       = 1'b0;
        for (int i = 0; i < 3; i++)
            walk[i] = 16'($urandom());
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first sample fills history, repeats give a zero axis.
        send_sample(16'sd100, 16'sd200, 16'sd300, '0);
        send_sample(16'sd100, 16'sd200, 16'sd300, 20'd5000);
        send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 20'd20000);
        send_sample(16'sd32767, -16'sd32768, 16'sd32767, '0);
        send_sample(-16'sd32768, -16'sd32768, 16'sd32767, 20'd1);
        send_sample(16'sd32767, 16'sd32767, -16'sd32768, 20'hFFFFF);
        // Axis parallel to the newest sample: zero projection.
        send_sample(16'sd0, 16'sd1, 16'sd1, 20'd10000);
        send_sample(16'sd1, 16'sd0, 16'sd1, 20'd10000);
        send_sample(16'sd0, 16'sd0, 16'sd1, 20'd10000);
        // Short interval holds the rate; at the threshold too.
        send_sample(16'sd500, -16'sd700, 16'sd900, 20'd1000);
        send_sample(-16'sd800, 16'sd300, 16'sd100, 20'd999);
        send_sample(16'sd1000, 16'sd1000, -16'sd1000, 20'd1001);
        send_sample(16'sd2000, -16'sd50, 16'sd10, '0);
        send_sample(16'sd0, 16'sd0, 16'sd0, 20'd1000000);
        send_sample(16'sd1, -16'sd1, 16'sd2, 20'd1000000);
        send_sample(16'sd4, 16'sd3, -16'sd7, 20'd1);
        drain();

        // Phase: minimum interval zero, smallest initial interval, spare indexes ignored.
        write_reg(mfar_pkg::CFG_MIN_INTERVAL, '0);
        write_reg(mfar_pkg::CFG_INITIAL_INTERVAL, 20'd1);
        write_reg(CFG_SPARE_A, 20'hFFFFF);
        write_reg(CFG_SPARE_B, 20'h12345);
        settings_used++;
        send_sample(16'sd10, 16'sd20, 16'sd30, '0);
        random_samples(250);
        drain();

        // Phase: top of range; only full intervals above the minimum recompute.
        write_reg(mfar_pkg::CFG_INITIAL_INTERVAL, 20'd1000000);
        write_reg(mfar_pkg::CFG_MIN_INTERVAL, 20'd1000000);
        settings_used++;
        random_samples(150);
        drain();

        // Phase: back to defaults, no idling on either side.
        write_reg(mfar_pkg::CFG_INITIAL_INTERVAL, mfar_pkg::RESET_INITIAL_INTERVAL);
        write_reg(mfar_pkg::CFG_MIN_INTERVAL, mfar_pkg::RESET_MIN_INTERVAL);
        settings_used++;
        quiet = 1'b1;
        random_samples(250);
        drain();
        quiet = 1'b0;

        // Phase: every bit of the registers set, then a mid setting.
        write_reg(mfar_pkg::CFG_INITIAL_INTERVAL, 20'hFFFFF);
        write_reg(mfar_pkg::CFG_MIN_INTERVAL, 20'd3000);
        settings_used++;
        random_samples(175);
        drain();
        write_reg(mfar_pkg::CFG_MIN_INTERVAL, 20'hFFFFF);
        write_reg(mfar_pkg::CFG_MIN_INTERVAL, 20'd500);
        settings_used++;
        random_samples(175);
        drain();

        repeat (200) @(posedge clk);
        $display("Summary: %0d sample beats over %0d register settings, %0d rates recomputed.",
                 samples_sent, settings_used, recomputed_count);
        if (fail_count == 0 && rates_pending == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
